// ===== hw/rtl/sbf_pkg.sv =====
package sbf_pkg;

   // field widths
   localparam int PULSE_W = 16;
   localparam int VALUE_W = 11;
   localparam int BYTE_W  = 8;
   localparam int CHAN_W  = 4;

   // configuration port
   localparam int ADDR_W  = 4;
   localparam int DATA_W  = 32;

   // pulse window in microseconds
   localparam logic [PULSE_W-1:0] PULSE_LO = 16'd1000;
   localparam logic [PULSE_W-1:0] PULSE_HI = 16'd2000;

   // scaling datapath widths
   localparam int SPAN_W  = 10;                 // clamped pulse minus 1000
   localparam int DIFF_W  = VALUE_W + 1;        // signed out_max - out_min
   localparam int MAG_W   = SPAN_W + VALUE_W;   // |product|, below 2^21
   localparam int QIN_W   = MAG_W - 3;          // product / 8
   localparam int SUM_W   = VALUE_W + 2;        // signed out_min +/- quotient
   localparam logic [SPAN_W-1:0] SPAN_FULL = 10'd1000;

   // divide by 1000 = shift by 3, then multiply by ceil(2^23 / 125)
   localparam int RECIP_W     = 17;
   localparam int RECIP_SHIFT = 23;
   localparam int PROD_W      = QIN_W + RECIP_W;
   localparam logic [RECIP_W-1:0] RECIP_125 = 17'd67109;

   // frame bytes
   localparam logic [BYTE_W-1:0] START_BYTE    = 8'h0F;
   localparam logic [BYTE_W-1:0] END_BYTE      = 8'h00;
   localparam logic [BYTE_W-1:0] FLAG_FAILSAFE = 8'h08;
   localparam logic [BYTE_W-1:0] FLAG_LOST     = 8'h04;
   localparam logic [CHAN_W-1:0] CHAN_FIRST    = 4'd0;
   localparam logic [CHAN_W-1:0] CHAN_LAST     = 4'd15;

   // bit packer
   localparam int PACK_W    = 18;   // residual plus one shifted value
   localparam int RESID_W   = 7;    // bits left over after a byte
   localparam int CNT_W     = 3;
   localparam int TOTAL_W   = 5;
   localparam int GROUP_MAX = 4;    // most bytes one channel can emit
   localparam int LEFT_W    = 3;

   // register reset values
   localparam logic               ENABLE_RST  = 1'b1;
   localparam logic [VALUE_W-1:0] OUT_MIN_RST = 11'd173;
   localparam logic [VALUE_W-1:0] OUT_MAX_RST = 11'd1811;

   typedef enum logic [ADDR_W-3:0] {
      REG_ENABLE  = 2'd0,
      REG_OUT_MIN = 2'd1,
      REG_OUT_MAX = 2'd2
   } csr_idx_type;

   typedef struct packed {
      logic               enable;
      logic [VALUE_W-1:0] out_min;
      logic [VALUE_W-1:0] out_max;
   } cfg_type;

   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic               failsafe;
      logic               frame_lost;
   } val_beat_type;

endpackage

// ===== hw/rtl/sbf_req_if.sv =====
interface sbf_req_if;
   import sbf_pkg::*;

   logic               valid;
   logic               ready;
   logic [PULSE_W-1:0] channel_pulse;
   logic               failsafe;
   logic               frame_lost;

   modport source (output valid, channel_pulse, failsafe, frame_lost, input ready);
   modport sink   (input valid, channel_pulse, failsafe, frame_lost, output ready);
endinterface

// ===== hw/rtl/sbf_rsp_if.sv =====
interface sbf_rsp_if;
   import sbf_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] frame_byte;
   logic              frame_end;

   modport source (output valid, frame_byte, frame_end, input ready);
   modport sink   (input valid, frame_byte, frame_end, output ready);
endinterface

// ===== hw/rtl/sbf_csr.sv =====
module sbf_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [sbf_pkg::ADDR_W-1:0]  paddr,
   input  logic [sbf_pkg::DATA_W-1:0]  pwdata,
   output logic [sbf_pkg::DATA_W-1:0]  prdata,
   output logic                        pready,
   output sbf_pkg::cfg_type            cfg
);
   import sbf_pkg::*;

   logic               enable_ff,  enable_in;
   logic [VALUE_W-1:0] out_min_ff, out_min_in;
   logic [VALUE_W-1:0] out_max_ff, out_max_in;
   logic               wr;
   csr_idx_type        idx;

   assign pready = 1'b1;
   assign wr     = psel && penable && pwrite;
   assign idx    = csr_idx_type'(paddr[ADDR_W-1:2]);

   // register write decode
   always_comb begin
      enable_in  = enable_ff;
      out_min_in = out_min_ff;
      out_max_in = out_max_ff;
      if (wr) begin
         unique case (idx)
            REG_ENABLE:  enable_in  = pwdata[0];
            REG_OUT_MIN: out_min_in = pwdata[VALUE_W-1:0];
            REG_OUT_MAX: out_max_in = pwdata[VALUE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff  <= ENABLE_RST;
         out_min_ff <= OUT_MIN_RST;
         out_max_ff <= OUT_MAX_RST;
      end else begin
         enable_ff  <= enable_in;
         out_min_ff <= out_min_in;
         out_max_ff <= out_max_in;
      end
   end

   // read mux
   always_comb begin
      unique case (idx)
         REG_ENABLE:  prdata = DATA_W'(enable_ff);
         REG_OUT_MIN: prdata = DATA_W'(out_min_ff);
         REG_OUT_MAX: prdata = DATA_W'(out_max_ff);
         default:     prdata = '0;
      endcase
   end

   assign cfg.enable  = enable_ff;
   assign cfg.out_min = out_min_ff;
   assign cfg.out_max = out_max_ff;

endmodule

// ===== hw/rtl/sbf_scale.sv =====
module sbf_scale (
   input  logic                  clock,
   input  logic                  reset,
   input  sbf_pkg::cfg_type      cfg,
   sbf_req_if.sink               req,
   output sbf_pkg::val_beat_type out_beat,
   output logic                  out_valid,
   input  logic                  out_ready
);
   import sbf_pkg::*;

   // stage a: input register
   logic               a_valid_ff, a_valid_in;
   logic [PULSE_W-1:0] a_pulse_ff;
   logic               a_fs_ff, a_fl_ff;
   // stage b: |(p - 1000) * (max - min)|
   logic               b_valid_ff, b_valid_in;
   logic [MAG_W-1:0]   b_mag_ff, b_mag_in;
   logic               b_neg_ff, b_neg_in;
   logic               b_fs_ff, b_fl_ff;
   // stage c: quotient by 1000
   logic               c_valid_ff, c_valid_in;
   logic [VALUE_W-1:0] c_quot_ff, c_quot_in;
   logic               c_neg_ff;
   logic               c_fs_ff, c_fl_ff;
   // stage d: offset and clamp
   logic               d_valid_ff, d_valid_in;
   logic [VALUE_W-1:0] d_value_ff, d_value_in;
   logic               d_fs_ff, d_fl_ff;

   logic               a_ready, b_ready, c_ready, d_ready;
   logic               a_load, b_load, c_load, d_load;
   logic [SPAN_W-1:0]  span;
   logic [DIFF_W-1:0]  diff;
   logic [VALUE_W-1:0] abs_diff;
   logic [PROD_W-1:0]  prod;
   logic signed [SUM_W-1:0] lo_s, hi_s, sum_s;

   // stall chain, a stage moves when the next one is empty or moving
   assign d_ready   = !d_valid_ff || out_ready;
   assign c_ready   = !c_valid_ff || d_ready;
   assign b_ready   = !b_valid_ff || c_ready;
   assign a_ready   = !a_valid_ff || b_ready;
   assign req.ready = a_ready;

   assign a_load = a_ready;
   assign b_load = b_ready;
   assign c_load = c_ready;
   assign d_load = d_ready;

   // disabled beats are taken and dropped
   assign a_valid_in = req.valid && cfg.enable;
   assign b_valid_in = a_valid_ff;
   assign c_valid_in = b_valid_ff;
   assign d_valid_in = c_valid_ff;

   // clamp pulse and multiply by span of the output range
   always_comb begin
      if (a_pulse_ff < PULSE_LO) begin
         span = '0;
      end else if (a_pulse_ff > PULSE_HI) begin
         span = SPAN_FULL;
      end else begin
         span = SPAN_W'(a_pulse_ff - PULSE_LO);
      end
      diff     = {1'b0, cfg.out_max} - {1'b0, cfg.out_min};
      b_neg_in = diff[DIFF_W-1];
      abs_diff = b_neg_in ? VALUE_W'(-diff) : diff[VALUE_W-1:0];
      b_mag_in = MAG_W'(span) * MAG_W'(abs_diff);
   end

   // reciprocal multiply, exact floor over the whole product range
   always_comb begin
      prod      = PROD_W'(b_mag_ff[MAG_W-1:3]) * PROD_W'(RECIP_125);
      c_quot_in = prod[RECIP_SHIFT+VALUE_W-1:RECIP_SHIFT];
   end

   // add to out_min with sign, then constrain to out_min..out_max
   always_comb begin
      lo_s  = $signed({2'b00, cfg.out_min});
      hi_s  = $signed({2'b00, cfg.out_max});
      sum_s = c_neg_ff ? lo_s - $signed({2'b00, c_quot_ff})
                       : lo_s + $signed({2'b00, c_quot_ff});
      priority if (sum_s < lo_s) begin
         d_value_in = cfg.out_min;
      end else if (sum_s > hi_s) begin
         d_value_in = cfg.out_max;
      end else begin
         d_value_in = sum_s[VALUE_W-1:0];
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
      end else begin
         if (a_load) a_valid_ff <= a_valid_in;
         if (b_load) b_valid_ff <= b_valid_in;
         if (c_load) c_valid_ff <= c_valid_in;
         if (d_load) d_valid_ff <= d_valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (a_load) begin
         a_pulse_ff <= req.channel_pulse;
         a_fs_ff    <= req.failsafe;
         a_fl_ff    <= req.frame_lost;
      end
      if (b_load) begin
         b_mag_ff <= b_mag_in;
         b_neg_ff <= b_neg_in;
         b_fs_ff  <= a_fs_ff;
         b_fl_ff  <= a_fl_ff;
      end
      if (c_load) begin
         c_quot_ff <= c_quot_in;
         c_neg_ff  <= b_neg_ff;
         c_fs_ff   <= b_fs_ff;
         c_fl_ff   <= b_fl_ff;
      end
      if (d_load) begin
         d_value_ff <= d_value_in;
         d_fs_ff    <= c_fs_ff;
         d_fl_ff    <= c_fl_ff;
      end
   end

   assign out_valid           = d_valid_ff;
   assign out_beat.value      = d_value_ff;
   assign out_beat.failsafe   = d_fs_ff;
   assign out_beat.frame_lost = d_fl_ff;

endmodule

// ===== hw/rtl/sbf_pack.sv =====
module sbf_pack (
   input  logic                  clock,
   input  logic                  reset,
   input  sbf_pkg::val_beat_type in_beat,
   input  logic                  in_valid,
   output logic                  in_ready,
   sbf_rsp_if.source             rsp
);
   import sbf_pkg::*;

   logic [GROUP_MAX-1:0][BYTE_W-1:0] slot_ff, slot_in, grp;
   logic [LEFT_W-1:0]  left_ff, left_in, grp_len;
   logic               end_ff, end_in;
   logic [CHAN_W-1:0]  chan_ff, chan_in;
   logic [RESID_W-1:0] acc_ff, acc_in, base_acc;
   logic [CNT_W-1:0]   cnt_ff, cnt_in, base_cnt;
   logic [PACK_W-1:0]  bits;
   logic [TOTAL_W-1:0] total;
   logic [BYTE_W-1:0]  flags;
   logic               first, last, two, take, fire;

   assign first = (chan_ff == CHAN_FIRST);
   assign last  = (chan_ff == CHAN_LAST);
   assign fire  = rsp.valid && rsp.ready;
   // a new group fits once the last held byte leaves this cycle
   assign in_ready = (left_ff == '0) || ((left_ff == LEFT_W'(1)) && rsp.ready);
   assign take     = in_valid && in_ready;

   // merge the value into the leftover bits, lsb first
   always_comb begin
      base_acc = first ? '0 : acc_ff;
      base_cnt = first ? '0 : cnt_ff;
      bits     = PACK_W'(base_acc) | (PACK_W'(in_beat.value) << base_cnt);
      total    = TOTAL_W'(base_cnt) + TOTAL_W'(VALUE_W);
      two      = total[TOTAL_W-1];
      flags    = (in_beat.failsafe ? FLAG_FAILSAFE : '0)
               | (in_beat.frame_lost ? FLAG_LOST : '0);
   end

   // bytes this channel emits, in frame order
   always_comb begin
      grp = '0;
      priority if (first) begin
         grp[0]  = START_BYTE;
         grp[1]  = bits[7:0];
         grp[2]  = bits[15:8];
         grp_len = two ? LEFT_W'(3) : LEFT_W'(2);
      end else if (last) begin
         grp[0] = bits[7:0];
         if (two) begin
            grp[1]  = bits[15:8];
            grp[2]  = flags;
            grp[3]  = END_BYTE;
            grp_len = LEFT_W'(4);
         end else begin
            grp[1]  = flags;
            grp[2]  = END_BYTE;
            grp_len = LEFT_W'(3);
         end
      end else begin
         grp[0]  = bits[7:0];
         grp[1]  = bits[15:8];
         grp_len = two ? LEFT_W'(2) : LEFT_W'(1);
      end
   end

   // frame position and leftover bits
   always_comb begin
      chan_in = chan_ff;
      acc_in  = acc_ff;
      cnt_in  = cnt_ff;
      if (take) begin
         if (last) begin
            chan_in = CHAN_FIRST;
            acc_in  = '0;
            cnt_in  = '0;
         end else begin
            chan_in = chan_ff + CHAN_W'(1);
            acc_in  = two ? RESID_W'(bits[PACK_W-1:16]) : bits[RESID_W+7:8];
            cnt_in  = total[CNT_W-1:0];
         end
      end
   end

   // byte queue, head drives the result beat
   always_comb begin
      slot_in = slot_ff;
      left_in = left_ff;
      end_in  = end_ff;
      if (take) begin
         slot_in = grp;
         left_in = grp_len;
         end_in  = last;
      end else if (fire) begin
         slot_in = {BYTE_W'(0), slot_ff[GROUP_MAX-1:1]};
         left_in = left_ff - LEFT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff <= '0;
         end_ff  <= 1'b0;
         chan_ff <= CHAN_FIRST;
         acc_ff  <= '0;
         cnt_ff  <= '0;
      end else begin
         left_ff <= left_in;
         end_ff  <= end_in;
         chan_ff <= chan_in;
         acc_ff  <= acc_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
   end

   assign rsp.valid      = (left_ff != '0);
   assign rsp.frame_byte = slot_ff[0];
   assign rsp.frame_end  = end_ff && (left_ff == LEFT_W'(1));

endmodule

// ===== hw/rtl/sbus_frame_encoder.sv =====
// channel | dir | handshake      | payload
// req     | in  | valid / ready  | channel_pulse[15:0], failsafe, frame_lost
// rsp     | out | valid / ready  | frame_byte[7:0], frame_end
// csr     | in  | apb psel/pen   | enable @0x0, out_min @0x4, out_max @0x8
//
// a channel beat spends four register stages in the scaler (input, multiply,
// reciprocal multiply, offset and clamp), then its bytes leave one per cycle while
// rsp is ready. one to four bytes per channel, so a frame of 16 channels is 25 bytes
// on rsp; the single-byte result port sets the sustained rate.
// reset (synchronous) empties the pipeline and restarts the frame at channel 0.
// req is taken every cycle while the scaler has room; rsp stalls back up into req.
module sbus_frame_encoder (
   input  logic                        clock,
   input  logic                        reset,
   sbf_req_if.sink                     req,
   sbf_rsp_if.source                   rsp,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [sbf_pkg::ADDR_W-1:0]  paddr,
   input  logic [sbf_pkg::DATA_W-1:0]  pwdata,
   output logic [sbf_pkg::DATA_W-1:0]  prdata,
   output logic                        pready
);
   import sbf_pkg::*;

   cfg_type      cfg;
   val_beat_type val_beat;
   logic         val_valid;
   logic         val_ready;

   sbf_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   sbf_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req       (req),
      .out_beat  (val_beat),
      .out_valid (val_valid),
      .out_ready (val_ready)
   );

   sbf_pack u_pack (
      .clock    (clock),
      .reset    (reset),
      .in_beat  (val_beat),
      .in_valid (val_valid),
      .in_ready (val_ready),
      .rsp      (rsp)
   );

endmodule

// ===== hw/rtl/sbf_check.sv =====
module sbf_check (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [sbf_pkg::BYTE_W-1:0]  frame_byte,
   input logic                        frame_end
);
   import sbf_pkg::*;

   // reset leaves nothing to send and room for input
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("not empty after reset");

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(frame_byte) && $stable(frame_end))
      else $error("stalled result beat changed");

   // the frame closes with the end byte
   a_end_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && frame_end |-> frame_byte == END_BYTE)
      else $error("end marker on a nonzero byte");

   // input only backs up behind pending result bytes
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("input stalled with no result pending");

   // a waiting input beat always has result bytes ahead of it
   a_req_seen: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |-> rsp_valid)
      else $error("input beat stalled with no result pending");

endmodule

bind sbus_frame_encoder sbf_check u_sbf_check (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req.valid),
   .req_ready  (req.ready),
   .rsp_valid  (rsp.valid),
   .rsp_ready  (rsp.ready),
   .frame_byte (rsp.frame_byte),
   .frame_end  (rsp.frame_end)
);

// ===== tb/sbf_frame_checker.sv =====
`timescale 1ns / 1ps

module sbf_frame_checker (
   input  logic                       clock,
   input  logic                       reset,
   sbf_req_if                         req,
   sbf_rsp_if                         rsp,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic                       pready,
   input  logic [sbf_pkg::ADDR_W-1:0] paddr,
   input  logic [sbf_pkg::DATA_W-1:0] pwdata,
   output int                         fail_count,
   output int                         pending,
   output int                         bytes_checked,
   output int                         frames_checked
);
   import sbf_pkg::*;

   typedef struct packed {
      logic [BYTE_W-1:0] data;
      logic              last;
   } frame_beat_type;

   // bytes owed by the encoder, oldest first
   frame_beat_type frame_bytes_due[$];

   // shadow of the register file and of the packer state
   cfg_type             cfg;
   logic [CHAN_W-1:0]   chan_next;
   logic [PACK_W-1:0]   pack_bits;
   logic [TOTAL_W-1:0]  pack_count;

   // clamp the pulse to the window, then map it onto out_min..out_max
   function automatic logic [VALUE_W-1:0] scale_pulse(logic [PULSE_W-1:0] pulse);
      int p;
      int lo;
      int hi;
      int win_lo;
      int win_hi;
      int v;
      p      = pulse;
      lo     = cfg.out_min;
      hi     = cfg.out_max;
      win_lo = PULSE_LO;
      win_hi = PULSE_HI;
      if (p < win_lo) p = win_lo;
      if (p > win_hi) p = win_hi;
      // int division truncates toward zero, as needed when out_max < out_min
      v = lo + ((p - win_lo) * (hi - lo)) / (win_hi - win_lo);
      if (v < lo) v = lo;
      else if (v > hi) v = hi;
      return v[VALUE_W-1:0];
   endfunction

   function automatic void owe_byte(logic [BYTE_W-1:0] data, logic last);
      frame_beat_type b;
      b.data = data;
      b.last = last;
      frame_bytes_due.push_back(b);
   endfunction

   // work out the bytes one channel beat releases
   function automatic void encode_channel(logic [PULSE_W-1:0] pulse, logic fs, logic fl);
      logic [VALUE_W-1:0] value;
      logic [BYTE_W-1:0]  flags;
      if (!cfg.enable) return;
      if (chan_next == CHAN_FIRST) begin
         pack_bits  = '0;
         pack_count = '0;
         owe_byte(START_BYTE, 1'b0);
      end
      value      = scale_pulse(pulse);
      pack_bits  = pack_bits | (PACK_W'(value) << pack_count[2:0]);
      pack_count = TOTAL_W'(pack_count[2:0]) + TOTAL_W'(VALUE_W);
      while (pack_count >= BYTE_W) begin
         owe_byte(pack_bits[BYTE_W-1:0], 1'b0);
         pack_bits  = pack_bits >> BYTE_W;
         pack_count = pack_count - TOTAL_W'(BYTE_W);
      end
      if (chan_next == CHAN_LAST) begin
         flags = '0;
         if (fs) flags = flags | FLAG_FAILSAFE;
         if (fl) flags = flags | FLAG_LOST;
         owe_byte(flags, 1'b0);
         owe_byte(END_BYTE, 1'b1);
         chan_next  = CHAN_FIRST;
         pack_bits  = '0;
         pack_count = '0;
      end else begin
         chan_next = chan_next + 1'b1;
      end
   endfunction

   task automatic report_mismatch(string what, logic [BYTE_W-1:0] got, logic [BYTE_W-1:0] want);
      $display("%0t  frame check: %s, got 0x%02h want 0x%02h", $time, what, got, want);
      fail_count++;
   endtask

   always @(posedge clock) begin
      frame_beat_type want;
      if (reset) begin
         frame_bytes_due.delete();
         cfg.enable     = ENABLE_RST;
         cfg.out_min    = OUT_MIN_RST;
         cfg.out_max    = OUT_MAX_RST;
         chan_next      = CHAN_FIRST;
         pack_bits      = '0;
         pack_count     = '0;
         fail_count     = 0;
         bytes_checked  = 0;
         frames_checked = 0;
      end else begin
         // register writes land on the access cycle
         if (psel && penable && pwrite && pready) begin
            case (paddr[ADDR_W-1:2])
               REG_ENABLE:  cfg.enable  = pwdata[0];
               REG_OUT_MIN: cfg.out_min = pwdata[VALUE_W-1:0];
               REG_OUT_MAX: cfg.out_max = pwdata[VALUE_W-1:0];
               default: ;
            endcase
         end

         if (req.valid && req.ready)
            encode_channel(req.channel_pulse, req.failsafe, req.frame_lost);

         // compare each byte beat with the oldest byte owed
         if (rsp.valid && rsp.ready) begin
            if (frame_bytes_due.size() == 0) begin
               report_mismatch("byte with none owed", rsp.frame_byte, '0);
            end else begin
               want = frame_bytes_due.pop_front();
               if (rsp.frame_byte !== want.data)
                  report_mismatch("frame_byte", rsp.frame_byte, want.data);
               if (rsp.frame_end !== want.last)
                  report_mismatch("frame_end", BYTE_W'(rsp.frame_end), BYTE_W'(want.last));
               if (want.last) frames_checked++;
            end
            bytes_checked++;
         end
      end
      pending = frame_bytes_due.size();
   end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
   import sbf_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;

   sbf_req_if req_if ();
   sbf_rsp_if rsp_if ();

   logic              csr_psel;
   logic              csr_penable;
   logic              csr_pwrite;
   logic [ADDR_W-1:0] csr_paddr;
   logic [DATA_W-1:0] csr_pwdata;
   logic [DATA_W-1:0] csr_prdata;
   logic              csr_pready;

   int fail_count;
   int bytes_owed;
   int bytes_checked;
   int frames_checked;

   // stimulus bookkeeping
   int beats_sent    = 0;
   int beats_dropped = 0;
   int settings_run  = 0;
   int rsp_hold      = 0;
   bit req_gaps_on   = 1'b1;
   bit rsp_stalls_on = 1'b1;

   always #5 clock = ~clock;

   sbus_frame_encoder dut (
      .clock   (clock),
      .reset   (reset),
      .req     (req_if),
      .rsp     (rsp_if),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready)
   );

   sbf_frame_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req            (req_if),
      .rsp            (rsp_if),
      .psel           (csr_psel),
      .penable        (csr_penable),
      .pwrite         (csr_pwrite),
      .pready         (csr_pready),
      .paddr          (csr_paddr),
      .pwdata         (csr_pwdata),
      .fail_count     (fail_count),
      .pending        (bytes_owed),
      .bytes_checked  (bytes_checked),
      .frames_checked (frames_checked)
   );

   // mostly no gap, some short, a few long
   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // mostly in-window pulses, with weight on the clamp edges
   function automatic logic [PULSE_W-1:0] rand_pulse();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return PULSE_W'($urandom_range(1000, 2000));
      if (r < 70) return PULSE_W'($urandom_range(900, 2100));
      if (r < 80) begin
         case ($urandom_range(0, 5))
            0: return 16'd0;
            1: return 16'd999;
            2: return 16'd1000;
            3: return 16'd2000;
            4: return 16'd2001;
            default: return 16'hFFFF;
         endcase
      end
      return PULSE_W'($urandom_range(0, 65535));
   endfunction

   // result side back-pressure
   always @(negedge clock) begin
      if (rsp_hold > 0) begin
         rsp_hold--;
      end else if (!rsp_stalls_on) begin
         rsp_if.ready <= 1'b1;
      end else if ($urandom_range(0, 2) != 0) begin
         rsp_if.ready <= 1'b1;
         rsp_hold = $urandom_range(0, 6);
      end else begin
         rsp_if.ready <= 1'b0;
         rsp_hold = idle_len();
      end
   end

   // one channel beat, entered and left at a falling edge
   task automatic send_beat(logic [PULSE_W-1:0] pulse, logic fs, logic fl);
      int gap;
      gap = req_gaps_on ? idle_len() : 0;
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.valid         <= 1'b1;
      req_if.channel_pulse <= pulse;
      req_if.failsafe      <= fs;
      req_if.frame_lost    <= fl;
      do @(posedge clock); while (!req_if.ready);
      @(negedge clock);
      beats_sent++;
   endtask

   task automatic send_random(int count);
      for (int i = 0; i < count; i++)
         send_beat(rand_pulse(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
   endtask

   task automatic csr_write(csr_idx_type idx, logic [DATA_W-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // all owed bytes out, then time for a dropped beat to clear the scaler
   task automatic wait_drained();
      req_if.valid <= 1'b0;
      while (bytes_owed != 0) @(negedge clock);
      repeat (24) @(negedge clock);
   endtask

   // disabled stretch: beats go in and nothing comes out
   task automatic disabled_burst(int count);
      wait_drained();
      csr_write(REG_ENABLE, 32'd0);
      for (int i = 0; i < count; i++) begin
         send_beat(rand_pulse(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
         beats_dropped++;
      end
      wait_drained();
      csr_write(REG_ENABLE, 32'd1);
   endtask

   // pulse extremes and clamp edges for the opening frame
   logic [PULSE_W-1:0] edge_pulses [16] = '{
      16'd0, 16'd999, 16'd1000, 16'd1001, 16'd1499, 16'd1500, 16'd1999, 16'd2000,
      16'd2001, 16'hFFFF, 16'h5555, 16'hAAAA, 16'h8000, 16'd1250, 16'd1750, 16'd1000
   };

   // out_min / out_max pairs, swapped and degenerate ranges among them
   int range_lo [9] = '{0, 2047, 173, 1000, 0, 2047, 1811, -1, -1};
   int range_hi [9] = '{2047, 0, 1811, 1000, 0, 2047, 173, -1, -1};

   initial begin
      req_if.valid         = 1'b0;
      req_if.channel_pulse = '0;
      req_if.failsafe      = 1'b0;
      req_if.frame_lost    = 1'b0;
      rsp_if.ready         = 1'b0;
      csr_psel             = 1'b0;
      csr_penable          = 1'b0;
      csr_pwrite           = 1'b0;
      csr_paddr            = '0;
      csr_pwdata           = '0;

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // opening frame at reset ranges, both flags on the last channel
      for (int i = 0; i < 16; i++)
         send_beat(edge_pulses[i], i == 15, i == 15);
      settings_run++;

      // a frame broken by a disabled stretch picks up where it stopped
      send_beat(16'd1000, 1'b0, 1'b0);
      send_beat(16'd2000, 1'b0, 1'b0);
      send_beat(16'd1500, 1'b0, 1'b0);
      disabled_burst(3);
      send_beat(16'd0, 1'b0, 1'b0);
      send_beat(16'hFFFF, 1'b0, 1'b0);
      send_beat(16'd1333, 1'b0, 1'b0);

      // random phases, one range setting each
      for (int ph = 0; ph < 9; ph++) begin
         wait_drained();
         csr_write(REG_OUT_MIN, (range_lo[ph] < 0) ? $urandom_range(0, 2047) : range_lo[ph]);
         csr_write(REG_OUT_MAX, (range_hi[ph] < 0) ? $urandom_range(0, 2047) : range_hi[ph]);
         settings_run++;
         req_gaps_on   = !(ph == 1 || ph == 7);
         rsp_stalls_on = !(ph == 2 || ph == 7);
         if (ph == 4) begin
            send_random(20);
            disabled_burst(4);
            send_random(12);
         end else begin
            send_random(32);
         end
      end

      req_gaps_on   = 1'b1;
      rsp_stalls_on = 1'b1;
      wait_drained();
      repeat (30) @(negedge clock);

      $display("covered %0d channel beats (%0d dropped while disabled) over %0d range settings",
               beats_sent, beats_dropped, settings_run);
      $display("checked %0d frame bytes, %0d of them closing a frame",
               bytes_checked, frames_checked);
      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // watchdog
   initial begin
      #5_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
